// File: rtl/core/cfrd_pkg.sv
// Package of constants and types shared by the frame deframer.
`timescale 1ns / 1ps
package cfrd_pkg;
  localparam int unsigned RingDepth = 2048;
  localparam int unsigned AddrW = $clog2(RingDepth);
  localparam int unsigned CountW = $clog2(RingDepth + 1);
  localparam int unsigned MaxFrame = 1024;
  localparam int unsigned MinFrame = 11;
  localparam int unsigned Overhead = 6;
  localparam int unsigned LenW = 17;
  localparam logic [7:0] StartMark = 8'h5B;
  localparam logic [7:0] EndMark = 8'h5D;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_RESUME = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;
endpackage

// File: rtl/core/cfrd_if.sv
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps
interface cfrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic [10:0] read_index;
  modport source(output valid, command, data_byte, read_index, input ready);
  modport sink(input valid, command, data_byte, read_index, output ready);
endinterface

interface cfrd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_found;
  logic [10:0] frame_start;
  logic [10:0] frame_length;
  logic [10:0] resync_drops;
  logic        scan_pending;
  logic [7:0]  read_byte;
  modport source(output valid, frame_found, frame_start, frame_length, resync_drops,
                 scan_pending, read_byte, input ready);
  modport sink(input valid, frame_found, frame_start, frame_length, resync_drops,
               scan_pending, read_byte, output ready);
endinterface

// File: rtl/core/checksummed_frame_resync_deframer.sv
// Top level: ring store, frame scanner and result register.
// A push while a scan is held, or an unknown command, sets the result register directly;
// a read registers the ring byte, then the result. A scan probes for the start mark, reads the
// length field, runs a checksum pass; an empty buffer ends it. All reads share one ring port.
// One item is in work at a time; the next transfer is taken the cycle after the result leaves.
// Reset clears head, count, pending flag and control; ring contents stay undefined.
`timescale 1ns / 1ps
module checksummed_frame_resync_deframer
  import cfrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cfrd_in_if.sink    in_i,
  cfrd_out_if.source out_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SKIP_RD = 3'd1;
  localparam logic [2:0] S_SKIP_CHK = 3'd2;
  localparam logic [2:0] S_LEN2 = 3'd3;
  localparam logic [2:0] S_LEN3 = 3'd4;
  localparam logic [2:0] S_LEN_CHK = 3'd5;
  localparam logic [2:0] S_SUM = 3'd6;
  localparam logic [2:0] S_RD = 3'd7;

  logic [7:0] ring_q [RingDepth];
  logic [7:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic we;
  logic [AddrW-1:0] waddr;

  logic [2:0] state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic pend_q, pend_d;
  logic skipped_q, skipped_d;
  logic [10:0] drops_q, drops_d;
  logic [7:0] hi_q, hi_d;
  logic [10:0] len_q, len_d;
  logic [10:0] iss_q, iss_d;
  logic [10:0] roff_q, roff_d;
  logic rv_q, rv_d;
  logic [7:0] sum_q, sum_d;
  logic endok_q, endok_d;

  logic ov_q, ov_d;
  logic found_q, found_d;
  logic [10:0] fstart_q, fstart_d;
  logic [10:0] flen_q, flen_d;
  logic [10:0] odrops_q, odrops_d;
  logic opend_q, opend_d;
  logic [7:0] rbyte_q, rbyte_d;

  logic acc;
  logic [LenW-1:0] len_w;

  assign in_i.ready = (state_q == S_IDLE) && !ov_q;
  assign acc = in_i.valid && in_i.ready;
  assign len_w = LenW'({hi_q, rdata_q}) + LenW'(Overhead);

  assign we = acc && (in_i.command == CMD_PUSH) && (count_q != CountW'(RingDepth));
  assign waddr = head_q + count_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_q[waddr] <= in_i.data_byte;
    end
    rdata_q <= ring_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    count_d = count_q;
    pend_d = pend_q;
    skipped_d = skipped_q;
    drops_d = drops_q;
    hi_d = hi_q;
    len_d = len_q;
    iss_d = iss_q;
    roff_d = roff_q;
    rv_d = 1'b0;
    sum_d = sum_q;
    endok_d = endok_q;
    raddr = head_q;
    ov_d = ov_q && !out_o.ready;
    found_d = found_q;
    fstart_d = fstart_q;
    flen_d = flen_q;
    odrops_d = odrops_q;
    opend_d = opend_q;
    rbyte_d = rbyte_q;

    unique case (state_q)
      S_IDLE: begin
        raddr = in_i.read_index;
        if (acc) begin
          found_d = 1'b0;
          fstart_d = '0;
          flen_d = '0;
          odrops_d = '0;
          rbyte_d = '0;
          opend_d = pend_q;
          case (in_i.command)
            CMD_PUSH: begin
              if (we) begin
                count_d = count_q + CountW'(1);
              end
              if (pend_q) begin
                ov_d = 1'b1;
              end else begin
                state_d = S_SKIP_RD;
              end
            end
            CMD_RESUME: state_d = S_SKIP_RD;
            CMD_READ: state_d = S_RD;
            default: ov_d = 1'b1;
          endcase
          if (state_d == S_SKIP_RD) begin
            pend_d = 1'b0;
            drops_d = '0;
            skipped_d = 1'b0;
          end
        end
      end
      S_RD: begin
        rbyte_d = rdata_q;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SKIP_RD: begin
        raddr = head_q;
        if (count_q == '0) begin
          if (skipped_q && drops_q != '1) begin
            drops_d = drops_q + 11'd1;
          end
          odrops_d = (skipped_q && drops_q != '1) ? drops_q + 11'd1 : drops_q;
          opend_d = 1'b0;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SKIP_CHK;
        end
      end
      S_SKIP_CHK: begin
        if (rdata_q != StartMark) begin
          head_d = head_q + AddrW'(1);
          count_d = count_q - CountW'(1);
          skipped_d = 1'b1;
          state_d = S_SKIP_RD;
        end else begin
          skipped_d = 1'b0;
          if (skipped_q && drops_q != '1) begin
            drops_d = drops_q + 11'd1;
          end
          if (count_q < CountW'(4)) begin
            odrops_d = drops_d;
            opend_d = 1'b0;
            ov_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_LEN2;
          end
        end
      end
      S_LEN2: begin
        raddr = head_q + AddrW'(2);
        state_d = S_LEN3;
      end
      S_LEN3: begin
        raddr = head_q + AddrW'(3);
        hi_d = rdata_q;
        state_d = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (len_w < LenW'(MinFrame) || len_w > LenW'(MaxFrame)) begin
          head_d = head_q + AddrW'(1);
          count_d = count_q - CountW'(1);
          if (drops_q != '1) drops_d = drops_q + 11'd1;
          state_d = S_SKIP_RD;
        end else if (LenW'(count_q) < len_w) begin
          odrops_d = drops_q;
          opend_d = 1'b0;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          len_d = len_w[10:0];
          iss_d = '0;
          sum_d = '0;
          endok_d = 1'b0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        raddr = head_q + iss_q;
        if (iss_q < len_q) begin
          rv_d = 1'b1;
          roff_d = iss_q;
          iss_d = iss_q + 11'd1;
        end
        if (rv_q) begin
          if (roff_q == len_q - 11'd1) begin
            if (endok_q && rdata_q == sum_q) begin
              found_d = 1'b1;
              fstart_d = head_q;
              flen_d = len_q;
              head_d = head_q + len_q;
              count_d = count_q - CountW'(len_q);
              pend_d = count_q != CountW'(len_q);
              opend_d = count_q != CountW'(len_q);
              odrops_d = drops_q;
              ov_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              head_d = head_q + AddrW'(1);
              count_d = count_q - CountW'(1);
              if (drops_q != '1) drops_d = drops_q + 11'd1;
              state_d = S_SKIP_RD;
            end
            rv_d = 1'b0;
          end else begin
            sum_d = sum_q + rdata_q;
            if (roff_q == len_q - 11'd2) endok_d = (rdata_q == EndMark);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      count_q <= '0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      count_q <= count_d;
      pend_q <= pend_d;
      ov_q <= ov_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skipped_q <= skipped_d;
    drops_q <= drops_d;
    hi_q <= hi_d;
    len_q <= len_d;
    iss_q <= iss_d;
    roff_q <= roff_d;
    sum_q <= sum_d;
    endok_q <= endok_d;
    found_q <= found_d;
    fstart_q <= fstart_d;
    flen_q <= flen_d;
    odrops_q <= odrops_d;
    opend_q <= opend_d;
    rbyte_q <= rbyte_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.frame_found = found_q;
  assign out_o.frame_start = fstart_q;
  assign out_o.frame_length = flen_q;
  assign out_o.resync_drops = odrops_q;
  assign out_o.scan_pending = opend_q;
  assign out_o.read_byte = rbyte_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(RingDepth)) else $error("buffered count beyond ring depth");
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && found_q) |-> (flen_q >= 11'(MinFrame) && flen_q <= 11'(MaxFrame)))
    else $error("reported frame length out of range");
  a_sum_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (CountW'(len_q) <= count_q))
    else $error("checksum pass beyond buffered bytes");
endmodule
